// File: rtl/bsa_pkg.sv
// Shared types, constants and codes for the bitmap slot allocator.
// No dependencies.
package bsa_pkg;
   localparam int SLOTS_PER_BUCKET_DEF = 1024;
   localparam int NUM_BUCKETS_DEF      = 4;
   localparam int ADDR_W   = 28;
   localparam int INDEX_W  = 12;
   localparam int SIZE_W   = 16;
   localparam int WORD_W   = 32;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_FULL       = 2'd1;
   localparam logic [1:0] ST_MISALIGNED = 2'd2;
   localparam logic [1:0] ST_RANGE      = 2'd3;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [0:0] REG_ITEM_SIZE = 1'd0;

   // classified command handed from front to back
   typedef struct packed {
      logic                action;
      logic [1:0]          status;
      logic [ADDR_W-1:0]   slot;     // quotient for a free
   } cmd_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [ADDR_W-1:0]   slot_address;
      logic [INDEX_W-1:0]  slot_index;
   } rsp_type;
endpackage

// File: rtl/bsa_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on bsa_pkg.
interface bsa_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic [bsa_pkg::ADDR_W-1:0]  free_address;
   modport source (output valid, action, free_address, input ready);
   modport sink   (input valid, action, free_address, output ready);
endinterface

interface bsa_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [bsa_pkg::ADDR_W-1:0]   slot_address;
   logic [bsa_pkg::INDEX_W-1:0]  slot_index;
   modport source (output valid, status, slot_address, slot_index, input ready);
   modport sink   (input valid, status, slot_address, slot_index, output ready);
endinterface

// File: rtl/bsa_front.sv
// Front end: accepts request beats, checks range, divides free address by item size.
// Depends on bsa_pkg.
module bsa_front #(
   parameter int TOTAL_SLOTS = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         in_action,
   input  logic [bsa_pkg::ADDR_W-1:0]   in_addr,
   input  logic [bsa_pkg::SIZE_W-1:0]   item_size,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output bsa_pkg::cmd_type             cmd
);
   localparam int TW = $clog2(TOTAL_SLOTS + 1);
   localparam int SPAN_W = TW + bsa_pkg::SIZE_W;
   localparam int CW = $clog2(bsa_pkg::ADDR_W + 1);
   localparam logic [1:0] S_IDLE = 2'd0, S_DIV = 2'd1, S_OUT = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic [bsa_pkg::ADDR_W-1:0]   quo_ff, quo_in;
   logic [bsa_pkg::SIZE_W:0]     rem_ff, rem_in;
   logic [bsa_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   bsa_pkg::cmd_type             cmd_ff, cmd_in;
   logic [SPAN_W-1:0]            span;
   logic [bsa_pkg::SIZE_W:0]     trial;

   assign span = SPAN_W'(TOTAL_SLOTS) * SPAN_W'(item_size);
   assign in_ready = (state_ff == S_IDLE);
   assign cmd_valid = (state_ff == S_OUT);
   assign cmd = cmd_ff;
   assign trial = {rem_ff[bsa_pkg::SIZE_W-1:0], addr_ff[bsa_pkg::ADDR_W-1]};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      addr_in = addr_ff;
      cmd_in = cmd_ff;
      case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               cmd_in.action = in_action;
               cmd_in.status = bsa_pkg::ST_OK;
               cmd_in.slot = '0;
               if (in_action == bsa_pkg::ACT_ALLOC) begin
                  state_in = S_OUT;
               end else if (SPAN_W'(in_addr) >= span) begin
                  cmd_in.status = bsa_pkg::ST_RANGE;
                  state_in = S_OUT;
               end else begin
                  addr_in = in_addr;
                  rem_in = '0;
                  quo_in = '0;
                  cnt_in = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // one restoring-division bit per cycle
            addr_in = {addr_ff[bsa_pkg::ADDR_W-2:0], 1'b0};
            if (trial >= {1'b0, item_size}) begin
               rem_in = trial - {1'b0, item_size};
               quo_in = {quo_ff[bsa_pkg::ADDR_W-2:0], 1'b1};
            end else begin
               rem_in = trial;
               quo_in = {quo_ff[bsa_pkg::ADDR_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(bsa_pkg::ADDR_W - 1)) begin
               cmd_in.slot = quo_in;
               cmd_in.status = (rem_in != '0) ? bsa_pkg::ST_MISALIGNED : bsa_pkg::ST_OK;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (cmd_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      addr_ff <= addr_in;
      cmd_ff <= cmd_in;
   end
endmodule

// File: rtl/bsa_queue.sv
// Two-entry command queue between front and back.
// Depends on bsa_pkg.
module bsa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bsa_pkg::cmd_type  in_cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output bsa_pkg::cmd_type  out_cmd
);
   bsa_pkg::cmd_type mem_ff [2];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             push, pop;

   assign in_ready = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_cmd;
   end
endmodule

// File: rtl/bsa_back.sv
// Back end: bitmap memory, bucket counts, word scan for alloc, bit set for free.
// Depends on bsa_pkg.
module bsa_back #(
   parameter int SLOTS_PER_BUCKET = 1024,
   parameter int NUM_BUCKETS      = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  bsa_pkg::cmd_type            cmd,
   input  logic [bsa_pkg::SIZE_W-1:0]  item_size,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output bsa_pkg::rsp_type            rsp
);
   localparam int TOTAL = SLOTS_PER_BUCKET * NUM_BUCKETS;
   localparam int WORDS = (TOTAL + 31) / 32;
   localparam int WPB = (SLOTS_PER_BUCKET + 31) / 32;
   localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int BA = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int CNT_W = $clog2(SLOTS_PER_BUCKET + 1);
   localparam int SW = $clog2(TOTAL);
   localparam int WCW = $clog2(WPB + 1);
   localparam int BCW = $clog2(NUM_BUCKETS + 1);
   localparam int PW = bsa_pkg::ADDR_W;

   localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_PICK = 4'd2, S_RD = 4'd3,
                          S_WAIT = 4'd4, S_TEST = 4'd5, S_MUL = 4'd6, S_FREAD = 4'd7,
                          S_FWAIT = 4'd8, S_FWR = 4'd9, S_OUT = 4'd10;

   logic [bsa_pkg::WORD_W-1:0] map_mem [WORDS];
   logic [bsa_pkg::WORD_W-1:0] rd_ff;
   logic [CNT_W-1:0]           count_ff [NUM_BUCKETS];

   logic [3:0]        state_ff, state_in;
   logic [WA-1:0]     clr_ff;
   logic [BCW-1:0]    bkt_ff, bkt_in;
   logic [WCW-1:0]    wcnt_ff, wcnt_in;
   logic [WA-1:0]     word_ff, word_in;
   logic [SW-1:0]     slot_ff, slot_in;
   logic [PW-1:0]     fslot_ff;
   bsa_pkg::rsp_type  rsp_ff, rsp_in;
   logic              wr_en;
   logic [WA-1:0]     wr_addr;
   logic [bsa_pkg::WORD_W-1:0] wr_data;
   logic              dec_en, inc_en;
   logic [4:0]        ffs;
   logic              any;
   logic [PW+bsa_pkg::SIZE_W-1:0] prod;
   logic [BA-1:0]     bsel;

   always_comb begin
      ffs = '0;
      any = 1'b0;
      for (int i = bsa_pkg::WORD_W - 1; i >= 0; i--) begin
         if (rd_ff[i]) begin
            ffs = 5'(i);
            any = 1'b1;
         end
      end
   end

   assign bsel = BA'(bkt_ff);
   assign prod = (PW+bsa_pkg::SIZE_W)'(slot_ff) * (PW+bsa_pkg::SIZE_W)'(item_size);
   assign cmd_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp = rsp_ff;

   always_comb begin
      state_in = state_ff;
      bkt_in = bkt_ff;
      wcnt_in = wcnt_ff;
      word_in = word_ff;
      slot_in = slot_ff;
      rsp_in = rsp_ff;
      wr_en = 1'b0;
      wr_addr = word_ff;
      wr_data = rd_ff;
      dec_en = 1'b0;
      inc_en = 1'b0;
      case (state_ff)
         S_CLR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            wr_data = '1;
            if (clr_ff == WA'(WORDS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               rsp_in.status = cmd.status;
               rsp_in.slot_address = '0;
               rsp_in.slot_index = '0;
               bkt_in = '0;
               if (cmd.status != bsa_pkg::ST_OK) begin
                  state_in = S_OUT;
               end else if (cmd.action == bsa_pkg::ACT_ALLOC) begin
                  state_in = S_PICK;
               end else begin
                  word_in = WA'(cmd.slot >> 5);
                  state_in = S_FREAD;
               end
            end
         end
         S_PICK: begin
            // find first bucket with room
            if (bkt_ff == BCW'(NUM_BUCKETS)) begin
               rsp_in.status = bsa_pkg::ST_FULL;
               state_in = S_OUT;
            end else if (count_ff[bsel] >= CNT_W'(SLOTS_PER_BUCKET)) begin
               bkt_in = bkt_ff + 1'b1;
            end else begin
               word_in = WA'(bkt_ff * WPB);
               wcnt_in = '0;
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_WAIT;
         S_WAIT: state_in = S_TEST;
         S_TEST: begin
            // with SLOTS_PER_BUCKET a multiple of 32, every word scanned lies wholly inside the picked bucket
            if (any) begin
               slot_in = SW'({word_ff, ffs});
               wr_en = 1'b1;
               wr_data = rd_ff & ~(32'd1 << ffs);
               inc_en = 1'b1;
               state_in = S_MUL;
            end else if (wcnt_ff == WCW'(WPB - 1)) begin
               rsp_in.status = bsa_pkg::ST_FULL;
               state_in = S_OUT;
            end else begin
               wcnt_in = wcnt_ff + 1'b1;
               word_in = word_ff + 1'b1;
               state_in = S_RD;
            end
         end
         S_MUL: begin
            rsp_in.slot_address = prod[PW-1:0];
            rsp_in.slot_index = bsa_pkg::INDEX_W'(slot_ff);
            state_in = S_OUT;
         end
         S_FREAD: state_in = S_FWAIT;
         S_FWAIT: state_in = S_FWR;
         S_FWR: begin
            rsp_in.slot_index = fslot_ff[bsa_pkg::INDEX_W-1:0];
            if (!rd_ff[fslot_ff[4:0]]) begin
               wr_en = 1'b1;
               wr_data = rd_ff | (32'd1 << fslot_ff[4:0]);
               dec_en = 1'b1;
            end
            state_in = S_OUT;
         end
         S_OUT: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         clr_ff <= '0;
         for (int i = 0; i < NUM_BUCKETS; i++) count_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLR) clr_ff <= clr_ff + 1'b1;
         for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (inc_en && bsel == BA'(i)) count_ff[i] <= count_ff[i] + 1'b1;
            if (dec_en && fslot_ff[SW-1:0] / SLOTS_PER_BUCKET == i && count_ff[i] != '0)
               count_ff[i] <= count_ff[i] - 1'b1;
         end
      end
      if (state_ff == S_IDLE) fslot_ff <= cmd.slot;
      bkt_ff <= bkt_in;
      wcnt_ff <= wcnt_in;
      word_ff <= word_in;
      slot_ff <= slot_in;
      rsp_ff <= rsp_in;
      if (wr_en) map_mem[wr_addr] <= wr_data;
      rd_ff <= map_mem[word_ff];
   end
endmodule

// File: rtl/bitmap_slot_allocator_core.sv
// Bitmap slot allocator: front end divides and classifies, back end owns the bitmap.
// Alloc: the back end skips full buckets in S_PICK, then reads and tests words (S_RD, S_WAIT,
// S_TEST) until a free bit is found and scales the slot in S_MUL; free runs the 28-step divider.
// Throughput: one beat at a time through each half; the 2-entry queue overlaps them.
// Reset: synchronous, active high; a clearing pass that marks every bitmap word free
// (128 words by default) runs before the back end takes its first command.
module bitmap_slot_allocator_core #(
   parameter int SLOTS_PER_BUCKET = bsa_pkg::SLOTS_PER_BUCKET_DEF,
   parameter int NUM_BUCKETS      = bsa_pkg::NUM_BUCKETS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bsa_req_if.sink     req,
   bsa_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [bsa_pkg::SIZE_W-1:0] item_size_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   bsa_pkg::cmd_type f_cmd, q_cmd;
   bsa_pkg::rsp_type r;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[1:0] == 2'd0) ? {16'd0, item_size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_size_ff <= 16'd1;
      end else if (csr_psel && csr_penable && csr_pwrite &&
                   csr_paddr[1:0] == {1'b0, bsa_pkg::REG_ITEM_SIZE}) begin
         item_size_ff <= csr_pwdata[bsa_pkg::SIZE_W-1:0];
      end
   end

   bsa_front #(.TOTAL_SLOTS(SLOTS_PER_BUCKET * NUM_BUCKETS)) u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_action(req.action),
      .in_addr(req.free_address), .item_size(item_size_ff),
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   bsa_queue u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   bsa_back #(.SLOTS_PER_BUCKET(SLOTS_PER_BUCKET), .NUM_BUCKETS(NUM_BUCKETS)) u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .item_size(item_size_ff), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp(r)
   );

   assign rsp.status = r.status;
   assign rsp.slot_address = r.slot_address;
   assign rsp.slot_index = r.slot_index;
endmodule

// File: tb/sv/tb_bitmap_slot_allocator_core.sv
// Self-checking testbench for bitmap_slot_allocator_core: directed table, then random
// alloc/free traffic under several item sizes, checked against an in-bench predictor.
// Depends on bsa_pkg, bsa_if and the core RTL.
`timescale 1ns / 1ps

module tb_bitmap_slot_allocator_core;
   localparam int TOTAL_SLOTS   = bsa_pkg::SLOTS_PER_BUCKET_DEF * bsa_pkg::NUM_BUCKETS_DEF;
   localparam int FILL_TARGET   = bsa_pkg::SLOTS_PER_BUCKET_DEF + 16;
   localparam int IDLE_LIMIT    = 20000;
   localparam int DRAIN_CYCLES  = 60;
   localparam int LONG_HOLD     = 600;

   typedef struct {
      logic                       action;
      logic [bsa_pkg::ADDR_W-1:0] addr;
      bit                         typed;
      bsa_pkg::rsp_type           want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   bsa_req_if req ();
   bsa_rsp_if rsp ();

   bitmap_slot_allocator_core u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #2 clock = ~clock;

   // predictor state
   bit [TOTAL_SLOTS-1:0]        slot_free;
   int                          bucket_used [bsa_pkg::NUM_BUCKETS_DEF];
   logic [bsa_pkg::SIZE_W-1:0]  item_size;
   int                          held_slots [$];
   bsa_pkg::rsp_type            pending_rsp [$];

   int  errors = 0;
   int  rsp_seen = 0;
   int  idle_cycles = 0;
   int  burst_left = 0;
   bit  stim_done = 0;

   function automatic bsa_pkg::rsp_type predict_alloc_free(logic action,
                                                           logic [bsa_pkg::ADDR_W-1:0] addr);
      bsa_pkg::rsp_type r;
      longint  span;
      int      s;
      int      b;
      int      pos;
      r = '{status: bsa_pkg::ST_FULL, slot_address: '0, slot_index: '0};
      if (action == bsa_pkg::ACT_ALLOC) begin
         for (b = 0; b < bsa_pkg::NUM_BUCKETS_DEF; b++) begin
            if (bucket_used[b] >= bsa_pkg::SLOTS_PER_BUCKET_DEF) continue;
            for (s = b * bsa_pkg::SLOTS_PER_BUCKET_DEF;
                 s < (b + 1) * bsa_pkg::SLOTS_PER_BUCKET_DEF; s++) begin
               if (slot_free[s]) begin
                  slot_free[s] = 1'b0;
                  bucket_used[b]++;
                  held_slots.push_back(s);
                  r.status       = bsa_pkg::ST_OK;
                  r.slot_address = bsa_pkg::ADDR_W'(longint'(s) * item_size);
                  r.slot_index   = bsa_pkg::INDEX_W'(s);
                  return r;
               end
            end
            break;
         end
         return r;
      end
      span = longint'(TOTAL_SLOTS) * item_size;
      if (longint'(addr) >= span) begin
         r.status = bsa_pkg::ST_RANGE;
         return r;
      end
      if (addr % item_size != 0) begin
         r.status = bsa_pkg::ST_MISALIGNED;
         return r;
      end
      s = addr / item_size;
      if (!slot_free[s]) begin
         slot_free[s] = 1'b1;
         b = s / bsa_pkg::SLOTS_PER_BUCKET_DEF;
         if (bucket_used[b] > 0) bucket_used[b]--;
         foreach (held_slots[i]) begin
            if (held_slots[i] == s) pos = i;
         end
         held_slots.delete(pos);
      end
      r.status     = bsa_pkg::ST_OK;
      r.slot_index = bsa_pkg::INDEX_W'(s);
      return r;
   endfunction

   // offer one beat, hold it until taken, then record the expected response
   task automatic send_beat(logic action, logic [bsa_pkg::ADDR_W-1:0] addr, bit typed,
                            bsa_pkg::rsp_type want);
      bsa_pkg::rsp_type got;
      int      gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req.valid        <= 1'b1;
      req.action       <= action;
      req.free_address <= addr;
      do @(posedge clock); while (!req.ready);
      got = predict_alloc_free(action, addr);
      pending_rsp.push_back(typed ? want : got);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] paddr, logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= paddr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (paddr == 2'(4 * bsa_pkg::REG_ITEM_SIZE)) item_size = data[bsa_pkg::SIZE_W-1:0];
   endtask

   task automatic set_item_size(logic [bsa_pkg::SIZE_W-1:0] sz);
      wait_idle();
      csr_write(2'(4 * bsa_pkg::REG_ITEM_SIZE), 32'(sz));
   endtask

   // mix of allocs, well-formed frees of held slots and noisy addresses
   task automatic run_traffic(int n, int alloc_pct);
      bsa_pkg::rsp_type           none;
      int                         r;
      int                         s;
      logic [bsa_pkg::ADDR_W-1:0] a;
      none = '0;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < alloc_pct) begin
            send_beat(bsa_pkg::ACT_ALLOC, bsa_pkg::ADDR_W'($urandom), 1'b0, none);
         end else if (r < alloc_pct + 30 && held_slots.size() != 0) begin
            s = held_slots[$urandom_range(0, held_slots.size() - 1)];
            send_beat(bsa_pkg::ACT_FREE, bsa_pkg::ADDR_W'(longint'(s) * item_size), 1'b0,
                      none);
         end else begin
            case ($urandom_range(0, 3))
               0: a = bsa_pkg::ADDR_W'($urandom);
               1: a = bsa_pkg::ADDR_W'(longint'($urandom_range(0, TOTAL_SLOTS - 1))
                                       * item_size);
               2: a = bsa_pkg::ADDR_W'(longint'($urandom_range(0, TOTAL_SLOTS - 1))
                                       * item_size
                                       + (item_size > 1 ? $urandom_range(1, item_size - 1)
                                                        : 0));
               default: a = bsa_pkg::ADDR_W'(longint'(TOTAL_SLOTS) * item_size
                                             + $urandom_range(0, 3));
            endcase
            send_beat(bsa_pkg::ACT_FREE, a, 1'b0, none);
         end
      end
   endtask

   dir_row_type dir_rows [] = '{
      '{bsa_pkg::ACT_ALLOC, 28'h0,       1'b1, '{bsa_pkg::ST_OK,    28'd0, 12'd0}},
      '{bsa_pkg::ACT_ALLOC, 28'hFFFFFFF, 1'b1, '{bsa_pkg::ST_OK,    28'd1, 12'd1}},
      '{bsa_pkg::ACT_ALLOC, 28'h0,       1'b0, '0},
      '{bsa_pkg::ACT_FREE,  28'h1,       1'b1, '{bsa_pkg::ST_OK,    28'd0, 12'd1}},
      '{bsa_pkg::ACT_FREE,  28'h1,       1'b1, '{bsa_pkg::ST_OK,    28'd0, 12'd1}},
      '{bsa_pkg::ACT_FREE,  28'd4095,    1'b1, '{bsa_pkg::ST_OK,    28'd0, 12'd4095}},
      '{bsa_pkg::ACT_FREE,  28'd4096,    1'b1, '{bsa_pkg::ST_RANGE, 28'd0, 12'd0}},
      '{bsa_pkg::ACT_FREE,  28'hFFFFFFF, 1'b1, '{bsa_pkg::ST_RANGE, 28'd0, 12'd0}},
      '{bsa_pkg::ACT_ALLOC, 28'h5555555, 1'b1, '{bsa_pkg::ST_OK,    28'd1, 12'd1}},
      '{bsa_pkg::ACT_FREE,  28'h0,       1'b1, '{bsa_pkg::ST_OK,    28'd0, 12'd0}},
      '{bsa_pkg::ACT_ALLOC, 28'hAAAAAAA, 1'b0, '0},
      '{bsa_pkg::ACT_ALLOC, 28'h0,       1'b0, '0},
      '{bsa_pkg::ACT_FREE,  28'h2,       1'b0, '0},
      '{bsa_pkg::ACT_ALLOC, 28'h0,       1'b0, '0}
   };

   // stimulus
   initial begin
      int i;
      slot_free = '1;
      foreach (bucket_used[b]) bucket_used[b] = 0;
      item_size        = 1;
      req.valid        = 1'b0;
      req.action       = bsa_pkg::ACT_ALLOC;
      req.free_address = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (dir_rows[k])
         send_beat(dir_rows[k].action, dir_rows[k].addr, dir_rows[k].typed, dir_rows[k].want);
      run_traffic(200, 55);
      set_item_size(16'hFFFF);
      run_traffic(120, 50);
      set_item_size(16'h0000);
      run_traffic(80, 50);
      set_item_size(16'd7);
      run_traffic(120, 50);
      set_item_size(16'($urandom_range(2, 65535)));
      run_traffic(120, 45);
      // fill past the first bucket so allocs move on to the next one
      set_item_size(16'd3);
      i = 0;
      while (held_slots.size() < FILL_TARGET && i < FILL_TARGET) begin
         send_beat(bsa_pkg::ACT_ALLOC, bsa_pkg::ADDR_W'($urandom), 1'b0, '0);
         i++;
      end
      repeat (6) send_beat(bsa_pkg::ACT_ALLOC, '0, 1'b0, '0);
      run_traffic(80, 40);
      set_item_size(16'd1);
      run_traffic(60, 40);
      wait_idle();
      stim_done = 1;
      if (errors == 0)
         $display("tb_bitmap_slot_allocator_core passed");
      else
         $display("tb_bitmap_slot_allocator_core failed");
      $finish;
   end

   // response side: check beats, stall on a pattern, hold off once for a long stretch
   initial begin
      int      stall_mode;
      int      mode_cnt;
      int      hold_cnt;
      bit      held_once;
      bsa_pkg::rsp_type want;
      stall_mode = 0;
      mode_cnt   = 0;
      hold_cnt   = 0;
      held_once  = 0;
      rsp.ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) begin
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp.status);
                  errors++;
               end
               if (rsp.slot_address !== want.slot_address) begin
                  $error("slot_address: expected %0h, got %0h",
                         want.slot_address, rsp.slot_address);
                  errors++;
               end
               if (rsp.slot_index !== want.slot_index) begin
                  $error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
                  errors++;
               end
            end
         end
         if (!held_once && rsp_seen == 200) begin
            held_once = 1;
            hold_cnt  = LONG_HOLD;
         end
         if (mode_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_cnt   = $urandom_range(16, 128);
         end
         mode_cnt--;
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp.ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp.ready <= 1'b1;
               1: rsp.ready <= ($urandom_range(0, 1) == 1);
               default: rsp.ready <= ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   // watchdog: count cycles with no accepted beat on either channel
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || reset || stim_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_bitmap_slot_allocator_core failed");
         $finish;
      end
   end
endmodule
